[design/tagged_score_table_depth_replace_macros.svh]
// Assertion macros for the tagged score table.
// Used by the top level; no other dependencies.
`ifndef TAGGED_SCORE_TABLE_DEPTH_REPLACE_MACROS_SVH
`define TAGGED_SCORE_TABLE_DEPTH_REPLACE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define TSTDR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tstdr: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define TSTDR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tstdr: next-cycle check failed");
`else
`define TSTDR_ASSERT_IMP(label, clk, rst, ante, cons)
`define TSTDR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

[design/tstdr_pkg.sv]
// Package for the tagged score table: sizes, item and result types, codes.
// No dependencies; imported by the front end, back end, result queue and top level.
`default_nettype none

package tstdr_pkg;

  // Table geometry and field widths.
  localparam int INDEX_BITS = 16;
  localparam longint unsigned TABLE_DEPTH = 64'd1 << INDEX_BITS;
  localparam int HASH_BITS = 64;
  localparam int TAG_BITS = 32;
  localparam int TAG_LSB = HASH_BITS - TAG_BITS;
  localparam int VALUE_BITS = 16;
  localparam int SCORE_BITS = 16;

  // Operation codes.
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // One input item.
  typedef struct packed {
    op_t                   op;
    logic [HASH_BITS-1:0]  hash;
    logic [VALUE_BITS-1:0] new_value;
    logic [SCORE_BITS-1:0] new_score;
  } in_t;

  // One result item.
  typedef struct packed {
    logic                  hit;
    logic                  written;
    logic [VALUE_BITS-1:0] value_out;
    logic [SCORE_BITS-1:0] score_out;
  } out_t;

  // Stored table word: tag, value, score from high to low bits.
  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [VALUE_BITS-1:0] value;
    logic [SCORE_BITS-1:0] score;
  } word_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic                  is_write;
    logic [INDEX_BITS-1:0] index;
    logic [TAG_BITS-1:0]   tag;
    logic [VALUE_BITS-1:0] value;
    logic [SCORE_BITS-1:0] score;
  } cmd_t;

  // Control from the back end to the front end.
  typedef struct packed {
    logic pop;
    logic hold;
  } back_ctl_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } back_state_t;

endpackage

`default_nettype wire

[design/tstdr_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module tstdr_ram #(
  parameter int WIDTH = 64,
  parameter longint unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word per cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

[design/tstdr_front.sv]
// Front end: accepts items, classifies them into commands, queues two.
// Depends on tstdr_pkg.
`default_nettype none

module tstdr_front
  import tstdr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire in_t       item,
  input  wire back_ctl_t ctl,
  output logic           cmd_valid,
  output cmd_t           cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       do_push;
  logic       do_pop;
  cmd_t       new_cmd;

  // Split the hash into index and tag and decode the operation.
  always_comb begin
    new_cmd.is_write = (item.op == OP_WRITE);
    new_cmd.index    = item.hash[INDEX_BITS-1:0];
    new_cmd.tag      = item.hash[TAG_LSB +: TAG_BITS];
    new_cmd.value    = item.new_value;
    new_cmd.score    = item.new_score;
  end

  // Handshake on both sides of the queue.
  assign full      = (count == 2'd2) || ctl.hold;
  assign do_push   = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign do_pop    = ctl.pop && cmd_valid;
  assign cmd       = slots[rd_ptr];

  // Occupancy update.
  always_comb begin
    count_next = count;
    case ({do_push, do_pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

[design/tstdr_back.sv]
// Back end: clears the table after reset, then reads, decides and writes back.
// Depends on tstdr_pkg and tstdr_ram.
`default_nettype none

module tstdr_back
  import tstdr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output back_ctl_t ctl,
  input  wire logic res_full,
  output logic      res_push,
  output out_t      res
);

  back_state_t           state;
  back_state_t           state_next;
  logic [INDEX_BITS-1:0] clear_addr;
  cmd_t                  cur;
  logic                  start;
  logic                  ram_en;
  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_addr;
  word_t                 ram_wdata;
  logic [$bits(word_t)-1:0] ram_rdata;
  word_t                 stored;
  logic                  tag_match;
  logic                  keep;

  tstdr_ram #(
    .WIDTH ($bits(word_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Compare the stored word against the command in flight.
  assign stored    = word_t'(ram_rdata);
  assign tag_match = (stored.tag == cur.tag);
  assign keep      = (stored != '0) && (cur.value <= stored.value) && tag_match;
  assign start     = cmd_valid && !res_full;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (&clear_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  // Memory port, queue control and result.
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = cur.index;
    ram_wdata = '{tag: cur.tag, value: cur.value, score: cur.score};
    ctl.pop   = 1'b0;
    ctl.hold  = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clear_addr;
        ram_wdata = '0;
        ctl.hold  = 1'b1;
      end
      ST_IDLE: begin
        ram_en   = start;
        ram_addr = cmd.index;
        ctl.pop  = start;
      end
      ST_EVAL: begin
        res_push = 1'b1;
        if (cur.is_write) begin
          ram_en      = !keep;
          ram_we      = !keep;
          res.written = !keep;
        end else if (tag_match) begin
          res.hit       = 1'b1;
          res.value_out = stored.value;
          res.score_out = stored.score;
        end
      end
      default: ctl.hold = 1'b1;
    endcase
  end

  // Sequencer state and clear sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  // Hold the command while its word is read back.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cur <= cmd;
    end
  end

endmodule

`default_nettype wire

[design/tstdr_out_queue.sv]
// Result queue of two entries between the back end and the result ports.
// Depends on tstdr_pkg.
`default_nettype none

module tstdr_out_queue
  import tstdr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic res_push,
  input  wire out_t res,
  output logic      res_full,
  input  wire logic pop,
  output logic      empty,
  output out_t      result
);

  out_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       do_push;
  logic       do_pop;

  // Handshake on both sides.
  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;
  assign result   = slots[rd_ptr];

  // Occupancy update.
  always_comb begin
    count_next = count;
    case ({do_push, do_pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= res;
    end
  end

endmodule

`default_nettype wire

[design/tagged_score_table_depth_replace.sv]
// Tagged score table with depth-preferred replacement.
// Both sides look like queues. An item transfers on a rising edge with push
// high and full low; it carries op (read or write), a 64-bit hash, a value
// and a score. The low INDEX_BITS hash bits pick a table word and the upper
// 32 bits are its tag. The oldest result sits on result while empty is low
// and transfers on an edge with pop high.
// Exactly one result per item, in order. A read reports hit, value and
// score; a write reports whether it replaced the stored word.
// After rst the table is swept to zero, one word per cycle, all 2^INDEX_BITS
// words (65536); full stays high during the sweep.
// Each item passes through the back-end idle state, which reads its word from
// the single-port table RAM, and then the eval state, which decides and writes
// back; the back end takes no new item until it is done with the last one.
// Two-entry queues sit on both sides; when pop stays low the result queue
// fills, the back end stops, and then full rises.
// Depends on tstdr_pkg, tstdr_front, tstdr_back, tstdr_out_queue and the
// assertion macro header.
`default_nettype none
`include "tagged_score_table_depth_replace_macros.svh"

module tagged_score_table_depth_replace
  import tstdr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire in_t  item,
  output logic      empty,
  input  wire logic pop,
  output out_t      result
);

  logic      cmd_valid;
  cmd_t      cmd;
  back_ctl_t ctl;
  logic      res_full;
  logic      res_push;
  out_t      res;

  tstdr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .ctl       (ctl),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  tstdr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .ctl       (ctl),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  tstdr_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

  // The clear sweep blocks input transfers right after reset.
  `TSTDR_ASSERT_IMP(a_full_after_reset, clk, rst, $past(rst), full)
  // The back end only takes a command that is queued.
  `TSTDR_ASSERT_IMP(a_pop_needs_cmd, clk, rst, ctl.pop, cmd_valid)
  // A result is never produced into a full result queue.
  `TSTDR_ASSERT_IMP(a_no_result_overflow, clk, rst, res_push, !res_full)
  // A command taken by the back end yields a result on the next cycle.
  `TSTDR_ASSERT_NXT(a_result_follows, clk, rst, ctl.pop, res_push)
  // A result never reports both a hit and a replacement.
  `TSTDR_ASSERT_IMP(a_hit_or_written, clk, rst, res_push, !(res.hit && res.written))

endmodule

`default_nettype wire
